// ===== rtl/core/gst_pkg.sv =====
// Package for the stack-based graph traversal: field widths and the sequencer states.
`default_nettype none

package gst_pkg;

	// Fixed widths of the beat fields.
	localparam int unsigned VERTEX_W   = 3;
	localparam int unsigned ROW_BITS_W = 8;

	// Item kinds carried in the kind field.
	localparam logic KIND_LOAD_ROW = 1'b0;
	localparam logic KIND_RUN      = 1'b1;

	// Traversal sequencer, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_RD_STACK = 5'b00010,
		ST_RD_ROW   = 5'b00100,
		ST_SCAN     = 5'b01000,
		ST_PUSH     = 5'b10000
	} gst_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/graph_stack_traversal.sv =====
// Stack-based depth-first traversal over an adjacency matrix held in on-chip memory.
//
// Input channel (in_valid / in_stall): a beat of kind 0 stores row_bits as the adjacency
// row of vertex row_index; a beat of kind 1 runs a traversal from start_vertex. Row bits
// at or above NUM_VERTICES are dropped, and out-of-range rows or start vertices are
// ignored without any result.
// Output channel (out_valid / out_stall): one beat per visited vertex, in visiting order,
// with last set on the final vertex of the run.
// A run takes each popped vertex through the stack read, row read and scan states, then
// pushes its new neighbours one at a time, as the stack memory has a single write port.
// in_stall is high for the whole run; the next beat is taken as soon as the run ends,
// even while the final result still waits in the output register.
// When the receiver stalls, the scan step waits with its result until the output register
// is free; the row read is held meanwhile, so nothing is lost or reordered.
// Reset clears the row valid bits (so every row reads as empty), the visited marks and the
// stack pointer. The stack memory is not cleared, as a run only reads entries it wrote.
`default_nettype none

module graph_stack_traversal #(
	parameter int NUM_VERTICES = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       kind,
	input  wire logic [2:0] row_index,
	input  wire logic [7:0] row_bits,
	input  wire logic [2:0] start_vertex,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [2:0]      vertex,
	output logic            last
);

	import gst_pkg::*;

	// Vertex index width, stack pointer width (holds 0..N) and loadable row bits.
	localparam int VW  = $clog2(NUM_VERTICES);
	localparam int SPW = $clog2(NUM_VERTICES + 1);
	localparam int LB  = (NUM_VERTICES < ROW_BITS_W) ? NUM_VERTICES : ROW_BITS_W;

	// Both stores are single-port-write memories with a registered read.
	logic [NUM_VERTICES-1:0] row_mem   [NUM_VERTICES];
	logic [VW-1:0]           stack_mem [NUM_VERTICES];

	gst_state_t              state_q;
	logic [SPW-1:0]          sp_q;
	logic [NUM_VERTICES-1:0] visited_q;
	logic [NUM_VERTICES-1:0] new_q;
	logic [NUM_VERTICES-1:0] row_valid_q;
	logic [VW-1:0]           v_q;
	logic                    row_ok_q;
	logic [NUM_VERTICES-1:0] row_rdata_q;
	logic [VW-1:0]           stk_rdata_q;
	logic                    out_valid_q;
	logic [VERTEX_W-1:0]     vertex_q;
	logic                    last_q;

	logic                    in_acc;
	logic                    row_in_range;
	logic                    start_in_range;
	logic [NUM_VERTICES-1:0] load_row;
	logic                    row_we;
	logic                    stk_we;
	logic [VW-1:0]           stk_waddr;
	logic [VW-1:0]           stk_wdata;
	logic [VW-1:0]           stk_raddr;
	logic [VW-1:0]           push_idx;
	logic [NUM_VERTICES-1:0] push_bit;
	logic [NUM_VERTICES-1:0] edges;
	logic [NUM_VERTICES-1:0] fresh;
	logic                    out_free;
	logic                    out_load;
	logic                    out_last_d;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	assign row_in_range   = (32'(row_index) < NUM_VERTICES);
	assign start_in_range = (32'(start_vertex) < NUM_VERTICES);

	// Incoming row, cut or widened to one bit per vertex.
	always_comb begin
		load_row = '0;
		for (int j = 0; j < LB; j++) begin
			load_row[j] = row_bits[j];
		end
	end

	assign row_we = in_acc && (kind == KIND_LOAD_ROW) && row_in_range;

	// Lowest unpushed neighbour goes first, so neighbours pop in descending order.
	always_comb begin
		push_idx = '0;
		for (int j = NUM_VERTICES - 1; j >= 0; j--) begin
			if (new_q[j]) begin
				push_idx = VW'(j);
			end
		end
	end
	assign push_bit = new_q & (~new_q + NUM_VERTICES'(1));

	// The start vertex is written into entry zero; later pushes go to the pointer.
	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = sp_q[VW-1:0];
		stk_wdata = push_idx;
		if (state_q == ST_IDLE) begin
			stk_we    = in_acc && (kind == KIND_RUN) && start_in_range;
			stk_waddr = '0;
			stk_wdata = VW'(start_vertex);
		end else if (state_q == ST_PUSH) begin
			stk_we = 1'b1;
		end
	end
	assign stk_raddr = sp_q[VW-1:0] - VW'(1);

	// A row that was never loaded reads as having no edges.
	assign edges      = row_ok_q ? row_rdata_q : '0;
	assign fresh      = edges & ~visited_q;
	assign out_free   = !out_valid_q || !out_stall;
	assign out_load   = (state_q == ST_SCAN) && out_free;
	assign out_last_d = (sp_q == '0) && (fresh == '0);

	// The row read is taken only for the popped vertex, so it holds through a stalled scan.
	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[VW'(row_index)] <= load_row;
		end
		if (state_q == ST_RD_ROW) begin
			row_rdata_q <= row_mem[stk_rdata_q];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[stk_waddr] <= stk_wdata;
		end
		stk_rdata_q <= stack_mem[stk_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sp_q        <= '0;
			visited_q   <= '0;
			new_q       <= '0;
			row_valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (row_we) begin
						row_valid_q[VW'(row_index)] <= 1'b1;
					end
					if (in_acc && (kind == KIND_RUN) && start_in_range) begin
						visited_q <= NUM_VERTICES'(1) << VW'(start_vertex);
						sp_q      <= SPW'(1);
						state_q   <= ST_RD_STACK;
					end
				end
				ST_RD_STACK: begin
					sp_q    <= sp_q - SPW'(1);
					state_q <= ST_RD_ROW;
				end
				ST_RD_ROW: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (out_free) begin
						visited_q <= visited_q | fresh;
						new_q     <= fresh;
						if (fresh != '0) begin
							state_q <= ST_PUSH;
						end else if (sp_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_RD_STACK;
						end
					end
				end
				ST_PUSH: begin
					sp_q  <= sp_q + SPW'(1);
					new_q <= new_q & ~push_bit;
					if ((new_q & ~push_bit) == '0) begin
						state_q <= ST_RD_STACK;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Popped vertex and its row-valid bit, taken as the stack read returns.
	always_ff @(posedge clk) begin
		if (state_q == ST_RD_ROW) begin
			v_q      <= stk_rdata_q;
			row_ok_q <= row_valid_q[stk_rdata_q];
		end
		if (out_load) begin
			vertex_q <= VERTEX_W'(v_q);
			last_q   <= out_last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign vertex    = vertex_q;
	assign last      = last_q;

	// The stack never holds more than one entry per vertex.
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(sp_q) <= NUM_VERTICES)
		else $error("stack pointer beyond vertex count");

	// A pop is only issued with something on the stack.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_STACK) |-> (sp_q != '0))
		else $error("pop from empty stack");

	// Neighbours waiting to be pushed are already marked visited.
	a_push_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH) |-> ((new_q & ~visited_q) == '0) && (new_q != '0))
		else $error("push of unmarked or missing neighbour");

	// The final result of a run returns the sequencer to idle.
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_last_d) |=> (state_q == ST_IDLE))
		else $error("run continues after final result");

	// The sequencer stays idle unless a beat is accepted.
	a_run_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) && $past(state_q == ST_IDLE) && !in_acc |=> (state_q == ST_IDLE))
		else $error("run started without an accepted beat");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the stack-based depth-first graph traversal block.
`timescale 1ns / 100ps

module testbench;
	import gst_pkg::*;

	// The block is built with its default vertex count of eight.
	localparam int NV            = 8;
	localparam int HALF_PERIOD   = 10;
	localparam int STALL_LIMIT   = 3000;
	// This tail covers anything still in flight once the last expected beat has been seen.
	localparam int TAIL_CYCLES   = 40;
	localparam int HOLDOFF_LEN   = 300;

	typedef struct packed {
		logic [2:0] vertex;
		logic       last;
	} visit_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic       in_stall;
	logic       kind         = KIND_LOAD_ROW;
	logic [2:0] row_index    = '0;
	logic [7:0] row_bits     = '0;
	logic [2:0] start_vertex = '0;
	logic       out_valid;
	logic       out_stall    = 1'b0;
	logic [2:0] vertex;
	logic       last;

	// Our own copy of the block's state: the adjacency rows and the visited marks.
	logic [NV-1:0] graph_rows [NV];
	logic [NV-1:0] visited_set;

	// Visits still owed by the block, oldest first.
	visit_t pending_visits [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int holdoff_left   = 0;
	int error_count    = 0;
	int rows_loaded    = 0;
	int runs_started   = 0;
	int visits_checked = 0;
	int quiet_cycles   = 0;

	graph_stack_traversal DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.row_index    (row_index),
		.row_bits     (row_bits),
		.start_vertex (start_vertex),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.vertex       (vertex),
		.last         (last)
	);

	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	// Works out the order in which a traversal from the given start visits the graph.
	// The start is marked before any scan, so a self loop never pushes it again.
	// Neighbours are pushed in ascending order and marked on push, which makes them
	// come off the stack in descending order; the final visit carries the last flag.
	function automatic void predict_visit_order(input logic [2:0] start);
		logic [2:0] stack_mem [NV];
		int         depth;
		int         visits;
		logic [2:0] here;
		visit_t     beat;
		visited_set        = '0;
		visited_set[start] = 1'b1;
		stack_mem[0]       = start;
		depth              = 1;
		visits             = 0;
		while (depth > 0 && visits < NV) begin
			depth--;
			here        = stack_mem[depth];
			beat.vertex = here;
			beat.last   = 1'b0;
			pending_visits.push_back(beat);
			visits++;
			for (int j = 0; j < NV; j++) begin
				if (graph_rows[here][j] && !visited_set[j]) begin
					stack_mem[depth] = j[2:0];
					depth++;
					visited_set[j] = 1'b1;
				end
			end
		end
		pending_visits[pending_visits.size() - 1].last = 1'b1;
	endfunction

	// Offers one beat and holds it until the block takes it. The beat is entered into
	// the prediction at the edge where it is accepted. Afterwards the sender may go
	// quiet for a random number of cycles; if it does not, valid stays high so that a
	// following call can put the next beat straight onto the bus.
	task automatic send_beat(input logic k, input logic [2:0] ri, input logic [7:0] rb,
			input logic [2:0] sv);
		in_valid     <= 1'b1;
		kind         <= k;
		row_index    <= ri;
		row_bits     <= rb;
		start_vertex <= sv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (k == KIND_LOAD_ROW) begin
			graph_rows[ri] = rb;
			rows_loaded++;
		end else begin
			predict_visit_order(sv);
			runs_started++;
		end
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// Takes valid down and waits until every owed visit has come back, then lets the
	// block settle for a while in case a stray beat follows.
	task automatic drain_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_visits.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] random_row();
		case ($urandom_range(2))
			0:       return 8'($urandom & $urandom);
			1:       return 8'($urandom | $urandom);
			default: return 8'($urandom);
		endcase
	endfunction

	// With every row empty after reset, a run visits only its start vertex.
	task automatic test_isolated_vertices();
		send_beat(KIND_RUN, 3'd0, 8'h00, 3'd0);
		send_beat(KIND_RUN, 3'd7, 8'hFF, 3'd7);
	endtask

	// A complete graph with self loops: every run visits all eight vertices, and the
	// start is never revisited through its own loop.
	task automatic test_complete_graph();
		for (int r = 0; r < NV; r++) begin
			send_beat(KIND_LOAD_ROW, r[2:0], 8'hFF, 3'd0);
		end
		send_beat(KIND_RUN, 3'd0, 8'h00, 3'd0);
		send_beat(KIND_RUN, 3'd7, 8'hFF, 3'd7);
	endtask

	// Alternating edge patterns, an emptied row, and repeated runs from one start.
	// The visited marks are cleared at the start of each run, so a repeat run must
	// give the same order again.
	task automatic test_patterns_and_reruns();
		send_beat(KIND_LOAD_ROW, 3'd5, 8'hAA, 3'd2);
		send_beat(KIND_LOAD_ROW, 3'd2, 8'h55, 3'd5);
		send_beat(KIND_LOAD_ROW, 3'd0, 8'h00, 3'd7);
		send_beat(KIND_RUN,      3'd1, 8'h3C, 3'd5);
		send_beat(KIND_RUN,      3'd6, 8'hC3, 3'd5);
		send_beat(KIND_RUN,      3'd4, 8'h81, 3'd2);
		send_beat(KIND_RUN,      3'd3, 8'h7E, 3'd0);
	endtask

	// Mostly well-formed sequences, a few rows loaded and then a run, with random
	// contents and densities. The rest is noise: lone runs and lone loads. Fields that
	// a beat's kind ignores still carry random values.
	task automatic test_random_graphs(input int beats, input int idle_pct,
			input int stall_pct);
		int sent;
		int rows_in_seq;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		sent           = 0;
		while (sent < beats) begin
			if ($urandom_range(99) < 80) begin
				rows_in_seq = $urandom_range(1, 4);
				repeat (rows_in_seq) begin
					send_beat(KIND_LOAD_ROW, 3'($urandom_range(NV - 1)), random_row(),
						3'($urandom_range(7)));
					sent++;
				end
				send_beat(KIND_RUN, 3'($urandom_range(7)), 8'($urandom),
					3'($urandom_range(NV - 1)));
				sent++;
			end else if ($urandom_range(1)) begin
				send_beat(KIND_RUN, 3'($urandom_range(7)), 8'($urandom),
					3'($urandom_range(NV - 1)));
				sent++;
			end else begin
				send_beat(KIND_LOAD_ROW, 3'($urandom_range(NV - 1)), random_row(),
					3'($urandom_range(7)));
				sent++;
			end
		end
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering a
	// full traversal and further beats, so the output register fills, the run stops
	// mid-way and the input stays stalled until the hold-off ends.
	task automatic test_output_holdoff();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		drain_block();
		holdoff_left = HOLDOFF_LEN;
		for (int r = 0; r < NV; r++) begin
			send_beat(KIND_LOAD_ROW, r[2:0], (r[0] ? 8'hFF : 8'h96), 3'd0);
		end
		send_beat(KIND_RUN,      3'd0, 8'h00, 3'd4);
		send_beat(KIND_LOAD_ROW, 3'd4, 8'h0F, 3'd0);
		send_beat(KIND_RUN,      3'd0, 8'h00, 3'd4);
	endtask

	// Checks each accepted result against the oldest owed visit and draws the stall
	// for the next cycle. A hold-off asked for by a test overrides the random stall.
	always @(posedge clk) begin
		visit_t owed;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_visits.size() == 0) begin
					$error("vertex: no visit owed, got %0d (last %0d)", vertex, last);
					error_count++;
				end else begin
					owed = pending_visits.pop_front();
					if (vertex !== owed.vertex) begin
						$error("vertex: expected %0d, got %0d", owed.vertex, vertex);
						error_count++;
					end
					if (last !== owed.last) begin
						$error("last: expected %0d, got %0d", owed.last, last);
						error_count++;
					end
				end
				visits_checked++;
			end
			if (holdoff_left > 0) begin
				out_stall <= 1'b1;
				holdoff_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Ends the run if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d cycles without a beat", quiet_cycles);
			$display("graph_stack_traversal: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		for (int r = 0; r < NV; r++) begin
			graph_rows[r] = '0;
		end
		visited_set = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_isolated_vertices();
		test_complete_graph();
		test_patterns_and_reruns();
		test_random_graphs(25, 0, 0);
		test_random_graphs(25, 81, 0);
		test_random_graphs(25, 0, 81);
		test_random_graphs(25, 34, 34);
		test_output_holdoff();
		drain_block();

		$display("Loaded %0d adjacency rows and ran %0d traversals, checking %0d visits,",
			rows_loaded, runs_started, visits_checked);
		$display("under free flow, sender gaps, receiver stalls, both, and one long hold-off.");
		if (error_count == 0) begin
			$display("graph_stack_traversal: match");
		end else begin
			$display("graph_stack_traversal: mismatch");
		end
		$finish;
	end

endmodule
